/* rtl/pofl_pkg.sv */
// Package for the power-of-two free-list allocator.
// Holds sizing constants, opcode and status codes, FSM states and controller/datapath structs.
// No dependencies.
package pofl_pkg;

   localparam int MIN_POWER   = 12;
   localparam int MAX_POWER   = 20;
   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int LEVELS      = MAX_POWER - MIN_POWER + 1;
   localparam int LVL_W       = $clog2(LEVELS + 1);
   localparam int LIDX_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int MEM_DEPTH   = LEVELS * STACK_DEPTH;
   localparam int MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NO_BLOCK  = 2'd2,
      ST_DROPPED   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_READ,
      S_SPLIT,
      S_FREE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic search;
      logic latch;
      logic split;
      logic free_step;
      logic clear;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic too_large;
      logic lvl_over;
      logic lvl_nonempty;
      logic at_base;
      logic free_done;
      logic rsp_free;
   } stat_type;

endpackage

/* rtl/pofl_ctrl.sv */
// Controller FSM for the power-of-two free-list allocator.
// Sequences allocate search/pop/split, range-free pushes and result handoff.
// Depends on pofl_pkg.
module pofl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  pofl_pkg::stat_type stat,
   output pofl_pkg::cmd_type  cmd
);
   import pofl_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (opcode_type'(req_opcode))
                  OP_ALLOC: state_in = stat.too_large ? S_DONE : S_SEARCH;
                  OP_FREE:  state_in = S_FREE;
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_DONE;
                  end
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.lvl_over) begin
               state_in = S_DONE;
            end else if (stat.lvl_nonempty) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.latch = 1'b1;
            state_in  = S_SPLIT;
         end
         S_SPLIT: begin
            if (stat.at_base) begin
               state_in = S_DONE;
            end else begin
               cmd.split = 1'b1;
            end
         end
         S_FREE: begin
            if (stat.free_done) begin
               state_in = S_DONE;
            end else begin
               cmd.free_step = 1'b1;
            end
         end
         S_DONE: begin
            // hold until the output register can take the word
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* rtl/pofl_dp.sv */
// Datapath for the power-of-two free-list allocator.
// Holds level counts, the free-offset memory, work registers and the result register.
// Depends on pofl_pkg.
module pofl_dp (
   input  logic               clock,
   input  logic               reset,
   input  pofl_pkg::cmd_type  cmd,
   output pofl_pkg::stat_type stat,
   input  logic [1:0]         req_opcode,
   input  logic [31:0]        req_request_size,
   input  logic [31:0]        req_range_start,
   input  logic [31:0]        req_range_end,
   input  logic               csr_valid,
   input  logic [31:0]        csr_disk_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_block_offset
);
   import pofl_pkg::*;

   localparam logic [DATA_W:0] MIN_BLOCK = (DATA_W+1)'(1) << MIN_POWER;
   localparam logic [DATA_W:0] MAX_BLOCK = (DATA_W+1)'(1) << MAX_POWER;

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]  cnt_ff [LEVELS];
   logic [DATA_W-1:0] disk_end_ff, offset_ff, cur_ff, end_ff;
   logic [LVL_W-1:0]  lvl_ff, base_ff;
   status_type        status_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [DATA_W-1:0] rsp_offset_ff;

   logic [DATA_W:0]   size_raised;
   logic              too_large;
   logic [LVL_W-1:0]  base_c;
   logic [DATA_W-1:0] end_min, end_clamped;
   logic              lvl_over;
   logic [LIDX_W-1:0] lidx, push_lidx;
   logic [CNT_W-1:0]  cnt_sel, push_cnt, pop_cnt;
   logic              pop_en, push_en, push_full;
   logic [DATA_W-1:0] rem;
   logic [LVL_W-1:0]  piece_lvl, push_lvl;
   logic [DATA_W-1:0] piece_bytes, push_data;
   logic [MEM_AW-1:0] rd_addr, wr_addr;

   // allocate setup: raise to minimum block, find smallest fitting level
   always_comb begin
      size_raised = {1'b0, req_request_size};
      if (size_raised < MIN_BLOCK) begin
         size_raised = MIN_BLOCK;
      end
      too_large = size_raised > MAX_BLOCK;
      base_c    = '0;
      for (int k = LEVELS - 1; k >= 0; k--) begin
         if (size_raised <= ((DATA_W+1)'(1) << (MIN_POWER + k))) begin
            base_c = LVL_W'(k);
         end
      end
   end

   // free setup: clamp end to disk end, never below start
   always_comb begin
      end_min     = (req_range_end > disk_end_ff) ? disk_end_ff : req_range_end;
      end_clamped = (end_min < req_range_start) ? req_range_start : end_min;
   end

   assign lvl_over = lvl_ff >= LVL_W'(LEVELS);
   assign lidx     = lvl_ff[LIDX_W-1:0];
   assign cnt_sel  = lvl_over ? '0 : cnt_ff[lidx];
   assign pop_en   = cmd.search && !lvl_over && (cnt_sel != '0);
   assign pop_cnt  = cnt_sel - CNT_W'(1);

   // greedy piece for range free: largest level block that fits the remainder
   always_comb begin
      rem       = end_ff - cur_ff;
      piece_lvl = '0;
      for (int k = 0; k < LEVELS; k++) begin
         if ({1'b0, rem} >= ((DATA_W+1)'(1) << (MIN_POWER + k))) begin
            piece_lvl = LVL_W'(k);
         end
      end
      piece_bytes = DATA_W'(1) << (MIN_POWER + int'(piece_lvl));
   end

   always_comb begin
      push_en   = cmd.split || cmd.free_step;
      push_lvl  = cmd.split ? (lvl_ff - LVL_W'(1)) : piece_lvl;
      push_lidx = push_lvl[LIDX_W-1:0];
      push_cnt  = cnt_ff[push_lidx];
      push_full = push_cnt >= CNT_W'(STACK_DEPTH);
      push_data = cmd.split
                ? offset_ff + (DATA_W'(1) << (MIN_POWER + int'(push_lvl)))
                : cur_ff;
      rd_addr   = MEM_AW'(lidx) * MEM_AW'(STACK_DEPTH) + MEM_AW'(pop_cnt[IDX_W-1:0]);
      wr_addr   = MEM_AW'(push_lidx) * MEM_AW'(STACK_DEPTH)
                + MEM_AW'(push_cnt[IDX_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (pop_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (push_en && !push_full) begin
         mem[wr_addr] <= push_data;
      end
   end

   // level counts
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int k = 0; k < LEVELS; k++) begin
            cnt_ff[k] <= '0;
         end
      end else if (pop_en) begin
         cnt_ff[lidx] <= pop_cnt;
      end else if (push_en && !push_full) begin
         cnt_ff[push_lidx] <= push_cnt + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_end_ff <= '1;
      end else if (csr_valid) begin
         disk_end_ff <= csr_disk_end;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= (opcode_type'(req_opcode) == OP_ALLOC && too_large) ? ST_TOO_LARGE
                                                                          : ST_OK;
         offset_ff <= '0;
         lvl_ff    <= base_c;
         base_ff   <= base_c;
         cur_ff    <= req_range_start;
         end_ff    <= end_clamped;
      end else begin
         if (cmd.search) begin
            if (lvl_over) begin
               status_ff <= ST_NO_BLOCK;
            end else if (!pop_en) begin
               lvl_ff <= lvl_ff + LVL_W'(1);
            end
         end
         if (cmd.latch) begin
            offset_ff <= rd_data_ff;
         end
         if (cmd.split) begin
            lvl_ff <= push_lvl;
         end
         if (cmd.free_step) begin
            cur_ff <= cur_ff + piece_bytes;
         end
         if (push_en && push_full) begin
            status_ff <= ST_DROPPED;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_offset_ff <= offset_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_offset = rsp_offset_ff;

   always_comb begin
      stat.too_large    = too_large;
      stat.lvl_over     = lvl_over;
      stat.lvl_nonempty = cnt_sel != '0;
      stat.at_base      = lvl_ff == base_ff;
      stat.free_done    = {1'b0, rem} < MIN_BLOCK;
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites a word not yet taken");

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.free_step |=> (cur_ff <= end_ff))
      else $error("range free stepped past the clamped end");

   a_split_above_base: assert property (@(posedge clock) disable iff (reset)
      cmd.split |-> (lvl_ff > base_ff))
      else $error("split below the requested level");

endmodule

/* rtl/power_of_two_free_list_allocator.sv */
// Top level of the power-of-two free-list allocator.
// Joins the controller (pofl_ctrl) and the datapath (pofl_dp); depends on pofl_pkg.
//
// Usage:
//   req_*  : one word per request (opcode, request_size, range_start, range_end).
//            Opcode 0 allocates, 1 frees a byte range, 2 empties all free stacks.
//   rsp_*  : exactly one word (status, block_offset) per request.
//   csr_*  : write of disk_end; always ready, write it only while the block is idle.
// Sequencing: clear, unused-opcode and oversize requests go from accept straight to the done state.
//   Allocate searches upward one level per cycle past empty levels, reads the popped offset, then
//   splits one level per cycle down to the requested level; a failed search ends past the top level.
//   Range free pushes one piece per cycle through the single memory write port.
// Throughput: one request at a time; req_ready is high only when the controller is idle.
//   A finished word waits in the output register, so the next request is taken and
//   worked on while rsp_ready is low; it stalls only at its own handoff.
// Reset: synchronous; all free stacks empty, disk_end = 0xFFFFFFFF, no result pending.
//   The offset memory is not cleared; only entries below a level's count are read.
module power_of_two_free_list_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_block_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_disk_end
);
   import pofl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   pofl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   pofl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_request_size (req_request_size),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .csr_valid        (csr_valid),
      .csr_disk_end     (csr_disk_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset)
   );

endmodule

/* bench/power_of_two_free_list_allocator_tb.sv */
// Testbench for the power-of-two free-list allocator. It drives requests and disk_end writes,
// predicts every response word in a scoreboard class, and checks it field by field.
// Depends on pofl_pkg and power_of_two_free_list_allocator.
`timescale 1ns / 100ps

module power_of_two_free_list_allocator_tb;
   import pofl_pkg::*;

   typedef struct {
      status_type  status;
      logic [31:0] offset;
   } alloc_word_type;

   class alloc_scoreboard;
      bit [31:0]   free_offsets [LEVELS][STACK_DEPTH];
      int          free_count [LEVELS];
      longint unsigned disk_end_q;
      alloc_word_type expected_words [$];
      int          mismatches;

      function new();
         foreach (free_count[k]) free_count[k] = 0;
         disk_end_q = 64'hFFFF_FFFF;
         mismatches = 0;
      endfunction

      function void set_disk_end(logic [31:0] value);
         disk_end_q = value;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function bit push_free(int lvl, longint unsigned off);
         if (lvl >= LEVELS || free_count[lvl] >= STACK_DEPTH) return 0;
         free_offsets[lvl][free_count[lvl]] = off[31:0];
         free_count[lvl]++;
         return 1;
      endfunction

      // Carve one span of at most the largest block size into greedy largest-fitting pieces from its start.
      function bit carve_span(longint unsigned s, longint unsigned e);
         bit ok;
         int fit;
         ok = 1;
         while (e > s && e - s >= (64'd1 << MIN_POWER)) begin
            fit = 0;
            while (fit < 63 && ((e - s) >> (fit + 1)) != 0) fit++;
            if (!push_free(fit - MIN_POWER, s)) ok = 0;
            s += 64'd1 << fit;
         end
         return ok;
      endfunction

      function void note_request(opcode_type op, logic [31:0] size, logic [31:0] rs,
                                 logic [31:0] re);
         alloc_word_type w;
         longint unsigned sz, s, e, i, maxb;
         int p, base, lvl;
         bit ok;
         w.status = ST_OK;
         w.offset = '0;
         maxb = 64'd1 << MAX_POWER;
         case (op)
            OP_ALLOC: begin
               sz = size;
               if (sz < (64'd1 << MIN_POWER)) sz = 64'd1 << MIN_POWER;
               p = 0;
               while (p < 63 && (64'd1 << p) < sz) p++;
               if (p > MAX_POWER) w.status = ST_TOO_LARGE;
               else begin
                  base = p - MIN_POWER;
                  lvl = base;
                  while (lvl < LEVELS && free_count[lvl] == 0) lvl++;
                  if (lvl >= LEVELS) w.status = ST_NO_BLOCK;
                  else begin
                     free_count[lvl]--;
                     w.offset = free_offsets[lvl][free_count[lvl]];
                     // push upper buddy halves down to the requested level
                     while (lvl > base) begin
                        lvl--;
                        if (!push_free(lvl, longint'(w.offset) + (64'd1 << (lvl + MIN_POWER))))
                           w.status = ST_DROPPED;
                     end
                  end
               end
            end
            OP_FREE: begin
               s = rs;
               e = re;
               ok = 1;
               if (e > disk_end_q) e = disk_end_q;
               if (e < s) e = s;
               if (e - s > maxb) begin
                  for (i = s; i + maxb < e; i += maxb)
                     if (!carve_span(i, i + maxb)) ok = 0;
                  if (!carve_span(i, e)) ok = 0;
               end else if (!carve_span(s, e)) ok = 0;
               if (!ok) w.status = ST_DROPPED;
            end
            OP_CLEAR: foreach (free_count[k]) free_count[k] = 0;
            default: ;
         endcase
         expected_words.insert(expected_words.size(), w);
      endfunction

      function void check_result(logic [1:0] status, logic [31:0] offset);
         alloc_word_type w;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: status %0d offset %h", status, offset);
            return;
         end
         w = expected_words.pop_front();
         if (status !== w.status || offset !== w.offset) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected status %0d offset %h, got %0d %h",
                        w.status, w.offset, status, offset);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_request_size = '0;
   logic [31:0] req_range_start = '0;
   logic [31:0] req_range_end = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_block_offset;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [31:0] csr_disk_end = '0;

   alloc_scoreboard sb = new();
   bit          long_hold = 0;
   bit          rsp_started = 0;

   always #1 clock = ~clock;

   power_of_two_free_list_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_request_size(req_request_size), .req_range_start(req_range_start),
      .req_range_end(req_range_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_block_offset(rsp_block_offset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_disk_end(csr_disk_end)
   );

   task automatic send_request(opcode_type op, logic [31:0] size, logic [31:0] rs,
                               logic [31:0] re);
      int gap;
      gap = $urandom_range(4);
      if ($urandom_range(9) < 3) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_request_size <= size;
      req_range_start <= rs;
      req_range_end <= re;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, size, rs, re);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_disk_end(logic [31:0] value);
      csr_valid <= 1'b1;
      csr_disk_end <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_disk_end(value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random();
      int r, k;
      logic [31:0] a, len;
      r = $urandom_range(99);
      if (r < 3) send_request(OP_CLEAR, $urandom, $urandom, $urandom);
      else if (r < 5) send_request(OP_NONE, $urandom, $urandom, $urandom);
      else if (r < 45) begin
         k = $urandom_range(9);
         if (k < 7) a = $urandom_range(0, 32'h0020_0000);
         else if (k < 9) a = 32'd1 << $urandom_range(MIN_POWER, MAX_POWER + 1);
         else a = $urandom;
         send_request(OP_ALLOC, a, $urandom, $urandom);
      end else if (r < 95) begin
         // aligned range of a few blocks at one level, sometimes ragged at the end
         k = $urandom_range(LEVELS - 1);
         a = $urandom & ~((32'd1 << (k + MIN_POWER)) - 1);
         len = 32'($urandom_range(1, 4)) << (k + MIN_POWER);
         if ($urandom_range(3) == 0) len += $urandom_range(0, 32'hFFFF);
         send_request(OP_FREE, $urandom, a, a + len);
      end else if (r < 98) begin
         a = $urandom;
         send_request(OP_FREE, $urandom, a, a + $urandom_range(0, 32'h0040_0000));
      end else send_request(OP_FREE, $urandom, $urandom, $urandom);
   endtask

   // Response side: random stalls, one long hold-off on request.
   initial begin
      int n;
      wait (rsp_started);
      forever begin
         n = $urandom_range(4);
         if ($urandom_range(9) < 3) n = 0;
         if (long_hold) begin
            n = 300;
            long_hold = 0;
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_status, rsp_block_offset);
      end
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [31:0] phase_end [4];
      phase_end[0] = 32'h0000_0000;
      phase_end[1] = 32'h0123_4000;
      phase_end[2] = $urandom;
      phase_end[3] = 32'hFFFF_FFFF;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      rsp_started = 1;

      // directed corners at the reset value of disk_end
      send_request(OP_ALLOC, 32'h0, '0, '0);
      send_request(OP_ALLOC, 32'hFFFF_FFFF, '0, '0);
      send_request(OP_ALLOC, 32'h0010_0001, '0, '0);
      send_request(OP_NONE, $urandom, $urandom, $urandom);
      send_request(OP_FREE, '0, 32'h0000_5000, 32'h0000_1000);
      send_request(OP_FREE, '0, 32'h0, 32'h0000_0FFF);
      send_request(OP_FREE, '0, 32'h0, 32'h0010_0000);
      send_request(OP_ALLOC, 32'h0, '0, '0);
      send_request(OP_ALLOC, 32'h0010_0000, '0, '0);
      send_request(OP_FREE, '0, 32'h0000_1000, 32'h0004_2000);
      send_request(OP_FREE, '0, 32'h0020_0000, 32'h0052_3000);
      send_request(OP_ALLOC, 32'h0000_3001, '0, '0);
      send_request(OP_ALLOC, 32'h0000_1000, '0, '0);
      send_request(OP_FREE, '0, 32'h0, 32'h5000_0000);
      send_request(OP_ALLOC, 32'h0008_0000, '0, '0);
      send_request(OP_FREE, '0, 32'hFFF0_0000, 32'hFFFF_FFFF);
      send_request(OP_CLEAR, '0, '0, '0);
      send_request(OP_ALLOC, 32'h0000_0001, '0, '0);
      drain();
      write_disk_end(32'h0);
      send_request(OP_FREE, '0, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_ALLOC, 32'h0000_1000, '0, '0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_disk_end(phase_end[ph]);
         for (int i = 0; i < 325; i++) begin
            if (ph == 1 && i == 100) long_hold = 1;
            // pause until every outstanding word is back
            if (ph == 2 && i == 150) begin
               req_valid <= 1'b0;
               while (sb.pending() > 0) @(posedge clock);
            end
            send_random();
         end
         drain();
      end

      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

/* power_of_two_free_list_allocator.f */
rtl/pofl_pkg.sv
rtl/pofl_ctrl.sv
rtl/pofl_dp.sv
rtl/power_of_two_free_list_allocator.sv
bench/power_of_two_free_list_allocator_tb.sv
